// ----- rtl/vrp_pkg.sv -----
package vrp_pkg;

    // data widths
    localparam int COORD_W  = 32;
    localparam int TRIG_W   = 16;
    localparam int UCFG_W   = 31;
    localparam int CFG_DW   = 32;
    localparam int CFG_IW   = 3;
    localparam int IDX_W    = 8;
    localparam int IDX_SPAN = 256;
    localparam int QUO_W    = 32;
    localparam int FRAC_W   = 16;

    // rotation rounding: Q2.14 coefficients, round half up
    localparam int TRIG_FRAC = 14;
    localparam int RND_HALF  = 1 << (TRIG_FRAC - 1);

    // divider: prep, prep, one stage per quotient bit, saturate
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_LAT   = DIV_STEPS + 3;

    localparam logic [QUO_W-1:0] SAT_MAX = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] SAT_MIN = {1'b1, {(QUO_W-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_SIN_X  = 3'd0,
        CFG_COS_X  = 3'd1,
        CFG_SIN_Y  = 3'd2,
        CFG_COS_Y  = 3'd3,
        CFG_SIN_Z  = 3'd4,
        CFG_COS_Z  = 3'd5,
        CFG_FOCAL  = 3'd6,
        CFG_DSCALE = 3'd7
    } vrp_cfg_idx_t;

    // reset values
    localparam logic [TRIG_W-1:0] RST_SIN   = 16'd0;
    localparam logic [TRIG_W-1:0] RST_COS   = 16'd16384;
    localparam logic [UCFG_W-1:0] RST_FOCAL = 31'd19660800;
    localparam logic [UCFG_W-1:0] RST_DSCALE = 31'd65536;

endpackage

// ----- rtl/vrp_delay.sv -----
module vrp_delay
    import vrp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // shift line that moves with the pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ----- rtl/vrp_rotate.sv -----
module vrp_rotate
    import vrp_pkg::*;
#(
    parameter int IN_W = 32
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [TRIG_W-1:0] sin_val,
    input  logic signed [TRIG_W-1:0] cos_val,
    input  logic signed [IN_W-1:0]   a,
    input  logic signed [IN_W-1:0]   b,
    output logic signed [IN_W+2:0]   out_a,
    output logic signed [IN_W+2:0]   out_b
);

    localparam int PW = IN_W + TRIG_W;
    localparam int SW = PW + 1;

    logic signed [PW-1:0]  ca, sb, sa, cb;
    logic signed [SW-1:0]  sum_a, sum_b;
    logic signed [IN_W+2:0] out_a_reg, out_b_reg;

    // plane rotation, exact products
    assign ca = cos_val * a;
    assign sb = sin_val * b;
    assign sa = sin_val * a;
    assign cb = cos_val * b;

    assign sum_a = SW'(ca) - SW'(sb) + SW'(RND_HALF);
    assign sum_b = SW'(sa) + SW'(cb) + SW'(RND_HALF);

    // floor shift back to 16 fraction bits as in Q16.16, three bits wider than the input
    always_ff @(posedge aclk) begin
        if (en) begin
            out_a_reg <= sum_a[SW-1:TRIG_FRAC];
            out_b_reg <= sum_b[SW-1:TRIG_FRAC];
        end
    end

    assign out_a = out_a_reg;
    assign out_b = out_b_reg;

endmodule

// ----- rtl/vrp_div_sat.sv -----
module vrp_div_sat
    import vrp_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 39
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic [QUO_W-1:0]        quo,
    output logic                    err
);

    localparam int NW = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 2;
    localparam int DW = DEN_W + 1;
    localparam int RW = (NW > DW + DIV_STEPS) ? NW : DW + DIV_STEPS;

    typedef struct packed {
        logic neg;
        logic den_zero;
        logic num_pos;
        logic num_neg;
        logic ovf;
    } div_flag_t;

    logic [NUM_W-1:0] an_reg;
    logic [DEN_W-1:0] ad_reg;
    div_flag_t        fa_reg;

    logic [RW-1:0]        rem_reg [DIV_STEPS+1];
    logic [DW-1:0]        d_reg   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS+1];
    div_flag_t            fl_reg  [DIV_STEPS+1];

    logic [RW-1:0] n_next;
    logic [DW-1:0] d_next;
    logic          ovf_next;

    logic [QUO_W-1:0]     quo_next, quo_reg;
    logic                 err_next, err_reg;
    logic [DIV_STEPS-1:0] q_fin;
    div_flag_t            f_fin;

    // magnitudes and signs
    always_ff @(posedge aclk) begin
        if (en) begin
            an_reg          <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            ad_reg          <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
            fa_reg.neg      <= num[NUM_W-1] != den[DEN_W-1];
            fa_reg.den_zero <= (den == '0);
            fa_reg.num_pos  <= !num[NUM_W-1] && (num != '0);
            fa_reg.num_neg  <= num[NUM_W-1];
            fa_reg.ovf      <= 1'b0;
        end
    end

    // rounded form: (2n + d) / 2d, with quotient overflow check
    always_comb begin
        n_next   = (RW'(an_reg) << 1) + RW'(ad_reg);
        d_next   = {ad_reg, 1'b0};
        ovf_next = n_next >= (RW'(d_next) << DIV_STEPS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= n_next;
            d_reg[0]   <= d_next;
            q_reg[0]   <= '0;
            fl_reg[0]  <= '{neg: fa_reg.neg, den_zero: fa_reg.den_zero,
                            num_pos: fa_reg.num_pos, num_neg: fa_reg.num_neg,
                            ovf: ovf_next};
        end
    end

    // one quotient bit per stage, restoring
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int SH = DIV_STEPS - 1 - j;
        logic [RW-1:0] trial;
        logic          take;

        assign trial = RW'(d_reg[j]) << SH;
        assign take  = rem_reg[j] >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= take ? rem_reg[j] - trial : rem_reg[j];
                q_reg[j+1]   <= {q_reg[j][DIV_STEPS-2:0], take};
                d_reg[j+1]   <= d_reg[j];
                fl_reg[j+1]  <= fl_reg[j];
            end
        end
    end

    assign q_fin = q_reg[DIV_STEPS];
    assign f_fin = fl_reg[DIV_STEPS];

    // sign and saturation
    always_comb begin
        err_next = 1'b0;
        if (f_fin.den_zero) begin
            err_next = 1'b1;
            if (f_fin.num_pos) begin
                quo_next = SAT_MAX;
            end else if (f_fin.num_neg) begin
                quo_next = SAT_MIN;
            end else begin
                quo_next = '0;
            end
        end else if (f_fin.neg) begin
            if (f_fin.ovf || (q_fin > SAT_MIN)) begin
                quo_next = SAT_MIN;
                err_next = 1'b1;
            end else begin
                quo_next = QUO_W'(0) - QUO_W'(q_fin);
            end
        end else begin
            if (f_fin.ovf || (q_fin > SAT_MAX)) begin
                quo_next = SAT_MAX;
                err_next = 1'b1;
            end else begin
                quo_next = QUO_W'(q_fin);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
            err_reg <= err_next;
        end
    end

    assign quo = quo_reg;
    assign err = err_reg;

endmodule

// ----- rtl/vertex_rotate_project_core.sv -----
// vertex rotate and perspective project, one vertex per clock while s_ready
// is high (low while the skid slot is occupied); the datapath runs through
// the bit-per-stage dividers (perspective divide, then screen and depth
// divides) in series; one word per cycle when not stalled, all stages pipelined
// aresetn (synchronous, active low) empties the pipeline and loads
// the default angles (identity), focal length 300.0 and depth scale 1.0
module vertex_rotate_project_core
    import vrp_pkg::*;
#(
    parameter int MAX_POINTS = 256
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [COORD_W-1:0] s_point_x,
    input  logic signed [COORD_W-1:0] s_point_y,
    input  logic signed [COORD_W-1:0] s_point_z,
    input  logic [IDX_W-1:0]         s_point_index,
    input  logic                     s_last_point,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [COORD_W-1:0] m_screen_x,
    output logic signed [COORD_W-1:0] m_screen_y,
    output logic signed [COORD_W-1:0] m_depth_out,
    output logic signed [COORD_W-1:0] m_scale_factor,
    output logic [IDX_W-1:0]         m_index_out,
    output logic                     m_last_out,
    output logic                     m_range_error
);

    localparam int PIPE_LAT = 2 * DIV_LAT + 4;
    localparam int W1 = COORD_W + 3;
    localparam int W2 = W1 + 3;
    localparam int W3 = W2 + 3;
    localparam int KDEN_W = W2 + 1;
    localparam int KNUM_W = UCFG_W + FRAC_W + 1;
    localparam int PROD_W = 2 * COORD_W;
    localparam int DNUM_W = W2 + FRAC_W + 1;
    localparam int XYD_W = 2 * COORD_W + 1 + W2;

    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic [COORD_W-1:0] depth;
        logic [COORD_W-1:0] scale;
        logic [IDX_W-1:0]   index;
        logic               last;
        logic               err;
    } vrp_result_t;

    // configuration registers
    logic signed [TRIG_W-1:0] sin_x_reg, cos_x_reg, sin_y_reg, cos_y_reg;
    logic signed [TRIG_W-1:0] sin_z_reg, cos_z_reg;
    logic [UCFG_W-1:0]        focal_reg, dscale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sin_x_reg  <= RST_SIN;
            cos_x_reg  <= RST_COS;
            sin_y_reg  <= RST_SIN;
            cos_y_reg  <= RST_COS;
            sin_z_reg  <= RST_SIN;
            cos_z_reg  <= RST_COS;
            focal_reg  <= RST_FOCAL;
            dscale_reg <= RST_DSCALE;
        end else if (cfg_valid) begin
            unique case (vrp_cfg_idx_t'(cfg_index))
                CFG_SIN_X:  sin_x_reg  <= cfg_data[TRIG_W-1:0];
                CFG_COS_X:  cos_x_reg  <= cfg_data[TRIG_W-1:0];
                CFG_SIN_Y:  sin_y_reg  <= cfg_data[TRIG_W-1:0];
                CFG_COS_Y:  cos_y_reg  <= cfg_data[TRIG_W-1:0];
                CFG_SIN_Z:  sin_z_reg  <= cfg_data[TRIG_W-1:0];
                CFG_COS_Z:  cos_z_reg  <= cfg_data[TRIG_W-1:0];
                CFG_FOCAL:  focal_reg  <= cfg_data[UCFG_W-1:0];
                CFG_DSCALE: dscale_reg <= cfg_data[UCFG_W-1:0];
                default:    ;
            endcase
        end
    end

    // pipeline advance: held only while the skid slot is occupied
    logic en;
    logic skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // valid bits
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    assign vld_next = {vld_reg[PIPE_LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // index wrap table
    logic [IDX_W-1:0] idx_wrap [IDX_SPAN];
    for (genvar g = 0; g < IDX_SPAN; g++) begin : g_idx
        assign idx_wrap[g] = IDX_W'(g % MAX_POINTS);
    end

    logic [IDX_W:0] side_q;
    vrp_delay #(.WIDTH(IDX_W + 1), .DEPTH(PIPE_LAT)) u_side (
        .aclk (aclk),
        .en   (en),
        .d    ({idx_wrap[s_point_index], s_last_point}),
        .q    (side_q)
    );

    // rotate about x
    logic signed [W1-1:0]      y1, z1;
    logic signed [COORD_W-1:0] px_s1_reg;

    vrp_rotate #(.IN_W(COORD_W)) u_rot_x (
        .aclk    (aclk),
        .en      (en),
        .sin_val (sin_x_reg),
        .cos_val (cos_x_reg),
        .a       (s_point_y),
        .b       (s_point_z),
        .out_a   (y1),
        .out_b   (z1)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            px_s1_reg <= s_point_x;
        end
    end

    // rotate about y
    logic signed [W2-1:0] z2, x2;
    logic signed [W1-1:0] y1_s2_reg;

    vrp_rotate #(.IN_W(W1)) u_rot_y (
        .aclk    (aclk),
        .en      (en),
        .sin_val (sin_y_reg),
        .cos_val (cos_y_reg),
        .a       (z1),
        .b       (W1'(px_s1_reg)),
        .out_a   (z2),
        .out_b   (x2)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            y1_s2_reg <= y1;
        end
    end

    // rotate about z, perspective denominator
    logic signed [W3-1:0]     x3, y3;
    logic signed [W2-1:0]     z2_s3_reg;
    logic signed [KDEN_W-1:0] kden_s3_reg;

    vrp_rotate #(.IN_W(W2)) u_rot_z (
        .aclk    (aclk),
        .en      (en),
        .sin_val (sin_z_reg),
        .cos_val (cos_z_reg),
        .a       (x2),
        .b       (W2'(y1_s2_reg)),
        .out_a   (x3),
        .out_b   (y3)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            z2_s3_reg   <= z2;
            kden_s3_reg <= $signed({{(KDEN_W-UCFG_W){1'b0}}, focal_reg}) + KDEN_W'(z2);
        end
    end

    // perspective factor
    logic [QUO_W-1:0] k_q;
    logic             k_err;

    vrp_div_sat #(.NUM_W(KNUM_W), .DEN_W(KDEN_W)) u_div_k (
        .aclk (aclk),
        .en   (en),
        .num  ($signed({1'b0, focal_reg, {FRAC_W{1'b0}}})),
        .den  (kden_s3_reg),
        .quo  (k_q),
        .err  (k_err)
    );

    // clamp x3, y3 and hold them, with z2, beside the divide
    logic                 x3_hi, x3_ovf, y3_hi, y3_ovf;
    logic [COORD_W-1:0]   x3_sat, y3_sat;
    logic [XYD_W-1:0]     xyd_q;
    logic signed [COORD_W-1:0] x3_d, y3_d;
    logic                 clamp_err_d;
    logic signed [W2-1:0] z2_d;

    assign x3_ovf = (x3[W3-1:COORD_W-1] != {(W3-COORD_W+1){x3[W3-1]}});
    assign y3_ovf = (y3[W3-1:COORD_W-1] != {(W3-COORD_W+1){y3[W3-1]}});
    assign x3_hi  = !x3[W3-1];
    assign y3_hi  = !y3[W3-1];
    assign x3_sat = x3_ovf ? (x3_hi ? SAT_MAX : SAT_MIN) : x3[COORD_W-1:0];
    assign y3_sat = y3_ovf ? (y3_hi ? SAT_MAX : SAT_MIN) : y3[COORD_W-1:0];

    vrp_delay #(.WIDTH(XYD_W), .DEPTH(DIV_LAT)) u_xy_dly (
        .aclk (aclk),
        .en   (en),
        .d    ({x3_sat, y3_sat, x3_ovf | y3_ovf, z2_s3_reg}),
        .q    (xyd_q)
    );

    assign {x3_d, y3_d, clamp_err_d, z2_d} = xyd_q;

    // scale products and depth numerator
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [DNUM_W-1:0] dnum_reg, dnum_next;
    logic [QUO_W-1:0]         k_m_reg;
    logic                     err_m_reg;

    assign dnum_next = -DNUM_W'($signed({z2_d, {FRAC_W{1'b0}}}));

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= x3_d * $signed(k_q);
            prod_y_reg <= y3_d * $signed(k_q);
            dnum_reg   <= dnum_next;
            k_m_reg    <= k_q;
            err_m_reg  <= clamp_err_d | k_err;
        end
    end

    // final divides by depth scale
    logic signed [COORD_W-1:0] ds_den;
    logic [QUO_W-1:0]          sx_q, sy_q, dep_q;
    logic                      sx_err, sy_err, dep_err;

    assign ds_den = $signed({1'b0, dscale_reg});

    vrp_div_sat #(.NUM_W(PROD_W), .DEN_W(COORD_W)) u_div_sx (
        .aclk (aclk), .en (en), .num (prod_x_reg), .den (ds_den),
        .quo (sx_q), .err (sx_err)
    );

    vrp_div_sat #(.NUM_W(PROD_W), .DEN_W(COORD_W)) u_div_sy (
        .aclk (aclk), .en (en), .num (prod_y_reg), .den (ds_den),
        .quo (sy_q), .err (sy_err)
    );

    vrp_div_sat #(.NUM_W(DNUM_W), .DEN_W(COORD_W)) u_div_dep (
        .aclk (aclk), .en (en), .num (dnum_reg), .den (ds_den),
        .quo (dep_q), .err (dep_err)
    );

    logic [QUO_W:0] km_q;
    vrp_delay #(.WIDTH(QUO_W + 1), .DEPTH(DIV_LAT)) u_k_dly (
        .aclk (aclk),
        .en   (en),
        .d    ({k_m_reg, err_m_reg}),
        .q    (km_q)
    );

    // assembled result word
    vrp_result_t pipe_res;
    logic        pipe_valid;

    assign pipe_valid        = vld_reg[PIPE_LAT-1];
    assign pipe_res.screen_x = sx_q;
    assign pipe_res.screen_y = sy_q;
    assign pipe_res.depth    = dep_q;
    assign pipe_res.scale    = km_q[QUO_W:1];
    assign pipe_res.index    = side_q[IDX_W:1];
    assign pipe_res.last     = side_q[0];
    assign pipe_res.err      = km_q[0] | sx_err | sy_err | dep_err;

    // output register with one skid slot
    vrp_result_t out_reg, skid_reg;
    logic        out_valid_reg;
    logic        pop;

    assign pop = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_valid) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (pipe_valid) begin
            if (!out_valid_reg || m_ready) begin
                out_reg <= pipe_res;
            end else begin
                skid_reg <= pipe_res;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_screen_x     = out_reg.screen_x;
    assign m_screen_y     = out_reg.screen_y;
    assign m_depth_out    = out_reg.depth;
    assign m_scale_factor = out_reg.scale;
    assign m_index_out    = out_reg.index;
    assign m_last_out     = out_reg.last;
    assign m_range_error  = out_reg.err;

endmodule
